// ===== rtl/core/lhc_pkg.sv =====
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared types and constants for the LRU file handle cache lookup block.
// ----------------------------------------------------------------------------
package lhc_pkg;

	// Request commands
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INVAL  = 1'b1;

	// Entry layout in the slot store: {file_id, tile_col, tile_row, stamp}
	localparam int KEY_W   = 48;
	localparam int STAMP_W = 32;
	localparam int ENTRY_W = KEY_W + STAMP_W;

	localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

	// Request transaction
	typedef struct packed {
		logic               cmd;
		logic        [15:0] file_id;
		logic signed [15:0] tile_col;
		logic signed [15:0] tile_row;
		logic        [2:0]  target_slot;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic       hit;
		logic [2:0] slot;
		logic       close_needed;
		logic [2:0] close_slot;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic req_is_inval;
		logic scan_last;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/core/lru_handle_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// lru_handle_cache_lookup
// Fully associative LRU slot table for open file handles.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready/req_data, one transaction per
//   lookup or invalidate. Each request yields exactly one response on
//   rsp_valid/rsp_ready/rsp_data, in order.
//   A lookup scans the slot store one slot per cycle through its single read
//   port; from acceptance to a loaded response it passes through accept, the
//   scan reads of all NUM_SLOTS slots, a read-latency drain and the commit.
//   An invalidate goes from accept straight to commit, with no scan.
//   The next request is accepted the cycle after the commit, so one request
//   is finished before the next is taken.
//   The response register lets a new request be accepted and scanned while
//   an earlier response waits; if the receiver stalls, the commit step holds
//   until the response register frees up, and no state changes meanwhile.
//   Reset empties all slots and zeroes the use clock at once; keys and stamps
//   in the store need no clearing, since only occupied slots are consulted.
// ----------------------------------------------------------------------------
module lru_handle_cache_lookup #(
	parameter int NUM_SLOTS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lhc_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lhc_pkg::rsp_t  rsp_data
);

	lhc_pkg::ctrl_cmd_t  cmd;
	lhc_pkg::dp_status_t status;

	lhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lhc_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== rtl/core/lhc_ram.sv =====
// ----------------------------------------------------------------------------
// lhc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/lhc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhc_ctrl
// Sequencer for the slot scan: accept, scan all slots, drain, then commit; an invalidate goes from accept to commit.
// ----------------------------------------------------------------------------
module lhc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lhc_pkg::dp_status_t status,
	output lhc_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode commands from the current state
	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		cmd.capture = req_valid && (state_q == ST_IDLE);
		cmd.scan    = (state_q == ST_SCAN);
		cmd.finish  = (state_q == ST_FINISH) && !status.out_busy;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = status.req_is_inval ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/lhc_datapath.sv =====
// ----------------------------------------------------------------------------
// lhc_datapath
// Slot store, per-slot flags, scan compare logic, use clock and response register.
// ----------------------------------------------------------------------------
module lhc_datapath #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lhc_pkg::req_t       req_data,
	input  lhc_pkg::ctrl_cmd_t  cmd,
	output lhc_pkg::dp_status_t status,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output lhc_pkg::rsp_t       rsp_data
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Report a slot index through the 3-bit field, keeping the low bits
	function automatic logic [2:0] to_slot(input logic [IW-1:0] idx);
		logic [IW+2:0] ext;
		ext = {3'b000, idx};
		return ext[2:0];
	endfunction

	lhc_pkg::req_t                   req_q;
	logic [NUM_SLOTS-1:0]            occ_q;
	logic [NUM_SLOTS-1:0]            usable_q;
	logic [lhc_pkg::STAMP_W-1:0]     use_clock_q;

	logic [IW-1:0]                   scan_cnt_q;
	logic                            cmp_vld_q;
	logic [IW-1:0]                   cmp_idx_q;
	logic                            found_q;
	logic [IW-1:0]                   match_q;
	logic                            empty_found_q;
	logic [IW-1:0]                   empty_idx_q;
	logic [IW-1:0]                   min_idx_q;
	logic [lhc_pkg::STAMP_W-1:0]     min_stamp_q;

	lhc_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic [lhc_pkg::ENTRY_W-1:0]     rd_entry;
	logic [lhc_pkg::KEY_W-1:0]       rd_key;
	logic [lhc_pkg::STAMP_W-1:0]     rd_stamp;
	logic [lhc_pkg::KEY_W-1:0]       req_key;

	logic                            is_inval;
	logic [IW+2:0]                   tgt_ext;
	logic [IW-1:0]                   tgt_idx;
	logic                            tgt_ok;
	logic                            hit_now;
	logic [IW-1:0]                   victim;
	logic                            close_now;
	logic [IW-1:0]                   close_idx;
	logic                            wr_en;

	assign req_key  = {req_q.file_id, req_q.tile_col, req_q.tile_row};
	assign rd_key   = rd_entry[lhc_pkg::ENTRY_W-1:lhc_pkg::STAMP_W];
	assign rd_stamp = rd_entry[lhc_pkg::STAMP_W-1:0];

	// Slot store: key and stamp per slot
	lhc_ram #(
		.WIDTH (lhc_pkg::ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (victim),
		.wdata ({req_key, use_clock_q}),
		.re    (cmd.scan),
		.raddr (scan_cnt_q),
		.rdata (rd_entry)
	);

	// Status toward the controller
	always_comb begin
		status.req_is_inval = (req_data.cmd == lhc_pkg::CMD_INVAL);
		status.scan_last    = (scan_cnt_q == IW'(NUM_SLOTS - 1));
		status.out_busy     = rsp_valid_q && !rsp_ready;
	end

	// Hold the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	// Scan address and compare pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			scan_cnt_q <= '0;
		end else if (cmd.scan) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
		end
		cmp_idx_q <= scan_cnt_q;
	end

	// Track first match, first empty slot and earliest smallest stamp
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmp_vld_q) begin
			if (!found_q && occ_q[cmp_idx_q] && (rd_key == req_key)) begin
				found_q <= 1'b1;
				match_q <= cmp_idx_q;
			end
			if (!empty_found_q && !occ_q[cmp_idx_q]) begin
				empty_found_q <= 1'b1;
				empty_idx_q   <= cmp_idx_q;
			end
			if ((cmp_idx_q == '0) || (rd_stamp < min_stamp_q)) begin
				min_idx_q   <= cmp_idx_q;
				min_stamp_q <= rd_stamp;
			end
		end
	end

	// Decide the outcome from the scan results
	always_comb begin
		is_inval  = (req_q.cmd == lhc_pkg::CMD_INVAL);
		tgt_ext   = {{IW{1'b0}}, req_q.target_slot};
		tgt_idx   = tgt_ext[IW-1:0];
		tgt_ok    = ({29'd0, req_q.target_slot} < 32'(NUM_SLOTS));
		hit_now   = found_q && usable_q[match_q];
		close_now = 1'b0;
		close_idx = '0;
		if (hit_now) begin
			victim = match_q;
		end else if (found_q) begin
			// Unusable match is emptied, so the first empty slot is the
			// earlier of the match and any slot already empty
			victim    = (empty_found_q && (empty_idx_q < match_q)) ? empty_idx_q : match_q;
			close_now = 1'b1;
			close_idx = match_q;
		end else if (empty_found_q) begin
			victim = empty_idx_q;
		end else begin
			victim    = min_idx_q;
			close_now = 1'b1;
			close_idx = min_idx_q;
		end
		wr_en = cmd.finish && !is_inval;
	end

	// Update slot flags and the use clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			usable_q    <= '0;
			use_clock_q <= '0;
		end else if (cmd.finish) begin
			if (is_inval) begin
				if (tgt_ok) begin
					usable_q[tgt_idx] <= 1'b0;
				end
			end else if (!hit_now) begin
				if (found_q) begin
					occ_q[match_q]    <= 1'b0;
					usable_q[match_q] <= 1'b0;
				end
				occ_q[victim]    <= 1'b1;
				usable_q[victim] <= 1'b1;
				if (use_clock_q != lhc_pkg::CLOCK_MAX) begin
					use_clock_q <= use_clock_q + 1'b1;
				end
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (is_inval) begin
				rsp_q.hit          <= 1'b0;
				rsp_q.slot         <= req_q.target_slot;
				rsp_q.close_needed <= 1'b0;
				rsp_q.close_slot   <= 3'd0;
			end else begin
				rsp_q.hit          <= hit_now;
				rsp_q.slot         <= to_slot(victim);
				rsp_q.close_needed <= close_now;
				rsp_q.close_slot   <= to_slot(close_idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
